>>> src/anv_pkg.sv
// ----------------------------------------------------------------------------
// anv_pkg
// Shared types and character constants for the attribute name validator.
// ----------------------------------------------------------------------------
package anv_pkg;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_UNDER = 8'h5F;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_DASH  = 8'h2D;

    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_CODE = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_CODE = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_CODE = 8'hF0;

    typedef struct packed {
        logic       is_zero;
        logic       is_colon;
        logic       is_slash;
        logic       is_high;
        logic       is_letter;
        logic       is_tail_ok;
        logic [1:0] lead_skip;
    } t_char_class;

    typedef struct packed {
        logic name_valid;
        logic accepted_as_iri;
    } t_verdict;

endpackage

>>> src/attribute_name_validator_core.sv
// ----------------------------------------------------------------------------
// attribute_name_validator_core
// Streaming attribute name checker, one byte per transaction.
// ----------------------------------------------------------------------------
// Bytes of a name arrive one per input transaction and a zero byte ends the
// name; only the terminator yields an output transaction, carrying the verdict
// and whether "://" occurred. Each byte is captured in an input register and
// retired from it through the grammar state; a terminator's verdict goes on
// into the result register. One byte is accepted every cycle while no
// terminator stalls. Non-zero bytes keep flowing while a verdict waits to
// be taken; only a second terminator stalls behind an untaken one.
// ----------------------------------------------------------------------------
module attribute_name_validator_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_char_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_name_valid,
    output logic       o_accepted_as_iri
);
    import anv_pkg::*;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_out_valid;
    t_verdict    r_verdict;
    t_char_class w_class;
    t_verdict    w_verdict;
    logic        w_step;

    anv_classify u_classify (
        .i_char_byte (r_in_byte),
        .o_class     (w_class)
    );

    anv_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_step),
        .i_class   (w_class),
        .o_verdict (w_verdict)
    );

    // a byte retires unless it is a terminator blocked by an untaken verdict
    assign w_step     = r_in_valid && (!w_class.is_zero || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_step && w_class.is_zero) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_char_byte;
        end
        if (w_step && w_class.is_zero) begin
            r_verdict <= w_verdict;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_name_valid      = r_verdict.name_valid;
    assign o_accepted_as_iri = r_verdict.accepted_as_iri;

endmodule

>>> src/anv_classify.sv
// ----------------------------------------------------------------------------
// anv_classify
// Decodes one name byte into the character classes used by the checker.
// ----------------------------------------------------------------------------
module anv_classify (
    input  logic [7:0]           i_char_byte,
    output anv_pkg::t_char_class o_class
);
    import anv_pkg::*;

    always_comb begin
        o_class.is_zero    = (i_char_byte == CHAR_NUL);
        o_class.is_colon   = (i_char_byte == CHAR_COLON);
        o_class.is_slash   = (i_char_byte == CHAR_SLASH);
        o_class.is_high    = i_char_byte[7];
        o_class.is_letter  = ((i_char_byte >= 8'h41) && (i_char_byte <= 8'h5A))
                          || ((i_char_byte >= 8'h61) && (i_char_byte <= 8'h7A));
        o_class.is_tail_ok = ((i_char_byte >= 8'h30) && (i_char_byte <= 8'h39))
                          || (i_char_byte == CHAR_UNDER)
                          || (i_char_byte == CHAR_DOT)
                          || (i_char_byte == CHAR_DASH);
        if ((i_char_byte & LEAD2_MASK) == LEAD2_CODE) begin
            o_class.lead_skip = 2'd1;
        end else if ((i_char_byte & LEAD3_MASK) == LEAD3_CODE) begin
            o_class.lead_skip = 2'd2;
        end else if ((i_char_byte & LEAD4_MASK) == LEAD4_CODE) begin
            o_class.lead_skip = 2'd3;
        end else begin
            o_class.lead_skip = 2'd0;
        end
    end

endmodule

>>> src/anv_checker.sv
// ----------------------------------------------------------------------------
// anv_checker
// Per-name grammar state: segment phase, utf-8 skip count, error flag and
// the "://" matcher. Produces the verdict for the terminating byte.
// ----------------------------------------------------------------------------
module anv_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  anv_pkg::t_char_class i_class,
    output anv_pkg::t_verdict    o_verdict
);
    import anv_pkg::*;

    typedef enum logic [1:0] {
        PH_NAME_START = 2'd0,
        PH_SEG_START  = 2'd1,
        PH_IN_SEG     = 2'd2
    } t_phase;

    t_phase     r_phase,    n_phase;
    logic [1:0] r_skip,     n_skip;
    logic       r_err,      n_err;
    logic [1:0] r_iri_prog, n_iri_prog;
    logic       r_iri_seen, n_iri_seen;
    logic       w_ok;

    always_comb begin
        o_verdict.accepted_as_iri = r_iri_seen;
        o_verdict.name_valid      = r_iri_seen || ((r_phase != PH_NAME_START) && !r_err);
    end

    always_comb begin
        n_phase    = r_phase;
        n_skip     = r_skip;
        n_err      = r_err;
        n_iri_prog = r_iri_prog;
        n_iri_seen = r_iri_seen;
        w_ok       = i_class.is_letter || ((r_phase == PH_IN_SEG) && i_class.is_tail_ok);

        if (i_class.is_zero) begin
            n_phase    = PH_NAME_START;
            n_skip     = 2'd0;
            n_err      = 1'b0;
            n_iri_prog = 2'd0;
            n_iri_seen = 1'b0;
        end else begin
            // "://" matcher
            if (i_class.is_colon) begin
                n_iri_prog = 2'd1;
            end else if (i_class.is_slash && (r_iri_prog == 2'd1)) begin
                n_iri_prog = 2'd2;
            end else if (i_class.is_slash && (r_iri_prog == 2'd2)) begin
                n_iri_seen = 1'b1;
                n_iri_prog = 2'd0;
            end else begin
                n_iri_prog = 2'd0;
            end

            // segment grammar
            if (i_class.is_colon) begin
                if (r_phase != PH_IN_SEG) begin
                    n_err = 1'b1;
                end
                n_phase = PH_SEG_START;
                n_skip  = 2'd0;
            end else if ((r_phase == PH_IN_SEG) && (r_skip != 2'd0)) begin
                n_skip = r_skip - 2'd1;
            end else if (i_class.is_high) begin
                n_skip  = i_class.lead_skip;
                n_phase = PH_IN_SEG;
            end else begin
                if (!w_ok) begin
                    n_err = 1'b1;
                end
                n_skip  = 2'd0;
                n_phase = PH_IN_SEG;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_NAME_START;
            r_skip     <= 2'd0;
            r_err      <= 1'b0;
            r_iri_prog <= 2'd0;
            r_iri_seen <= 1'b0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_skip     <= n_skip;
            r_err      <= n_err;
            r_iri_prog <= n_iri_prog;
            r_iri_seen <= n_iri_seen;
        end
    end

endmodule
